// File: sv/assert_macros.svh
// Assertion macros shared by the median filter RTL.
// Needs a clock named i_clk and an active-low synchronous reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define MFSP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define MFSP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/mfsp_pkg.sv
// Shared types and constants of the salt-and-pepper median filter.
// No dependencies; used by mfsp_if, median_filter_salt_pepper, mfsp_cell and mfsp_sort.
package mfsp_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 2;
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int WIN_MAX    = RING_ROWS * RING_ROWS;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int RSEL_W     = $clog2(RING_ROWS);
    localparam int ADDR_W     = RSEL_W + COL_W;
    localparam int DEPTH      = RING_ROWS * MAX_WIDTH;
    localparam int PIX_W      = 8;
    localparam int WREG_W     = 11;
    localparam int HREG_W     = 12;
    localparam int RREG_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DAT_W  = 12;
    localparam int LAG_W      = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y     = 3'd3;

    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

    // Link between neighboring sorter cells.
    typedef struct packed {
        logic             vld;
        logic [PIX_W-1:0] val;
        logic             gt;
    } t_link;

    // Control of the sorter chain.
    typedef struct packed {
        logic             clear;
        logic             ins;
        logic [PIX_W-1:0] x;
    } t_sort_ctl;
endpackage

// File: sv/mfsp_if.sv
// Handshake interfaces of the median filter: pixel input, result output, register writes.
// Depends on mfsp_pkg.
interface mfsp_pix_if;
    logic                       valid;
    logic                       ready;
    logic [mfsp_pkg::PIX_W-1:0] pixel_in;
    logic                       padding;
    modport source (output valid, output pixel_in, output padding, input ready);
    modport sink (input valid, input pixel_in, input padding, output ready);
endinterface

interface mfsp_res_if;
    logic                       valid;
    logic                       ready;
    logic [mfsp_pkg::PIX_W-1:0] pixel_out;
    logic                       last;
    modport source (output valid, output pixel_out, output last, input ready);
    modport sink (input valid, input pixel_out, input last, output ready);
endinterface

interface mfsp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mfsp_pkg::CFG_IDX_W-1:0] index;
    logic [mfsp_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/median_filter_salt_pepper.sv
// Salt-and-pepper median filter over a 3x3 up to 5x5 window, pixels in raster order.
// Depends on mfsp_pkg, mfsp_if, mfsp_ram, mfsp_sort and assert_macros.svh.
//
// Usage:
//   i_pix carries one grey pixel per beat, or a padding beat that flushes the
//   results still owed after the last pixel of a frame. o_res carries one
//   filtered pixel per result beat, with last on the frame's final pixel.
//   i_cfg writes image_width, image_height, radius_x and radius_y (indexes 0..3)
//   while the block is idle; any such write restarts the stream at row 0.
// Lag and window reads:
//   Results lag the input by radius_y rows plus radius_x pixels. For a beat
//   that yields an interior result, the single line-store read port fetches
//   the center and then every window pixel, one per cycle, into the sorter
//   chain. After a beat that yields a result, i_pix takes no new beat until
//   that result is in the output register.
// Reset clears all counters and the output valid flag; line-store contents are
//   not cleared and need no clearing pass.
// A stalled receiver holds the result in the output register; input beats are
//   still taken meanwhile until one yields a result, which then waits in the
//   sequencer until the register frees.
`include "assert_macros.svh"

module median_filter_salt_pepper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfsp_pix_if.sink    i_pix,
    mfsp_cfg_if.sink    i_cfg,
    mfsp_res_if.source  o_res
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam int COL_W  = mfsp_pkg::COL_W;
    localparam int RSEL_W = mfsp_pkg::RSEL_W;
    localparam int PIX_W  = mfsp_pkg::PIX_W;
    localparam int WREG_W = mfsp_pkg::WREG_W;
    localparam int HREG_W = mfsp_pkg::HREG_W;
    localparam int RREG_W = mfsp_pkg::RREG_W;
    localparam int LAG_W  = mfsp_pkg::LAG_W;

    // Configuration registers.
    logic [WREG_W-1:0] r_width;
    logic [HREG_W-1:0] r_height;
    logic [RREG_W-1:0] r_rx;
    logic [RREG_W-1:0] r_ry;

    // Control.
    logic [1:0]        r_state;
    logic [COL_W-1:0]  r_in_col;
    logic [HREG_W-1:0] r_in_row;
    logic [RSEL_W-1:0] r_in_m5;
    logic [COL_W-1:0]  r_out_col;
    logic [HREG_W-1:0] r_out_row;
    logic [RSEL_W-1:0] r_out_m5;
    logic [LAG_W-1:0]  r_lag;
    logic              r_interior;
    logic              r_first;
    logic [2:0]        r_dx;
    logic [2:0]        r_dy;
    logic              r_rd_v;
    logic              r_rd_ctr;
    logic [PIX_W-1:0]  r_center;
    logic              r_ov;
    logic [PIX_W-1:0]  r_opix;
    logic              r_olast;

    // Effective (clamped) settings.
    logic [WREG_W-1:0] w_eff;
    logic [HREG_W-1:0] h_eff;
    logic [RREG_W-1:0] rx_eff;
    logic [RREG_W-1:0] ry_eff;
    logic [LAG_W-1:0]  delay;

    always_comb begin
        w_eff = r_width;
        if (r_width < WREG_W'(5)) begin
            w_eff = WREG_W'(5);
        end else if (r_width > WREG_W'(mfsp_pkg::MAX_WIDTH)) begin
            w_eff = WREG_W'(mfsp_pkg::MAX_WIDTH);
        end
        h_eff  = (r_height < HREG_W'(5)) ? HREG_W'(5) : r_height;
        rx_eff = (r_rx == 2'd0) ? 2'd1 : ((r_rx > 2'(mfsp_pkg::MAX_RADIUS)) ?
                 2'(mfsp_pkg::MAX_RADIUS) : r_rx);
        ry_eff = (r_ry == 2'd0) ? 2'd1 : ((r_ry > 2'(mfsp_pkg::MAX_RADIUS)) ?
                 2'(mfsp_pkg::MAX_RADIUS) : r_ry);
        delay  = ((ry_eff == 2'd2) ? {LAG_W'(w_eff) << 1} : LAG_W'(w_eff)) + LAG_W'(rx_eff);
    end

    // Configuration port.
    logic cfg_hit;
    assign i_cfg.ready = 1'b1;
    assign cfg_hit = i_cfg.valid && (i_cfg.index == mfsp_pkg::REG_IMAGE_WIDTH ||
                     i_cfg.index == mfsp_pkg::REG_IMAGE_HEIGHT ||
                     i_cfg.index == mfsp_pkg::REG_RADIUS_X ||
                     i_cfg.index == mfsp_pkg::REG_RADIUS_Y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WREG_W'(640);
            r_height <= HREG_W'(480);
            r_rx     <= 2'd1;
            r_ry     <= 2'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mfsp_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg.data[WREG_W-1:0];
                mfsp_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg.data[HREG_W-1:0];
                mfsp_pkg::REG_RADIUS_X:     r_rx     <= i_cfg.data[RREG_W-1:0];
                mfsp_pkg::REG_RADIUS_Y:     r_ry     <= i_cfg.data[RREG_W-1:0];
                default: ;
            endcase
        end
    end

    // Input side.
    logic in_acc;
    logic is_pix;
    logic emit;
    logic in_col_end;
    logic out_interior;
    logic out_col_end;
    logic out_load;

    assign i_pix.ready = (r_state == ST_IDLE);
    assign in_acc      = i_pix.valid && i_pix.ready;
    assign is_pix      = !i_pix.padding;
    assign in_col_end  = ({1'b0, r_in_col} == w_eff - WREG_W'(1));
    assign out_col_end = ({1'b0, r_out_col} == w_eff - WREG_W'(1));

    always_comb begin
        if (is_pix) begin
            emit = (r_lag + LAG_W'(1)) > delay;
        end else begin
            emit = (r_in_col == '0) && (r_in_row == '0) && (r_lag != '0);
        end
    end

    assign out_interior = ({1'b0, r_out_col} >= WREG_W'(rx_eff)) &&
                          ({1'b0, r_out_col} + WREG_W'(rx_eff) < w_eff) &&
                          (r_out_row >= HREG_W'(ry_eff)) &&
                          ({1'b0, r_out_row} + 13'(ry_eff) < {1'b0, h_eff});

    // Window read address.
    logic [3:0]        row_sum;
    logic [RSEL_W-1:0] rd_row;
    logic [COL_W:0]    col_sum;
    logic [COL_W-1:0]  rd_col;
    logic              dx_end;
    logic              dy_end;

    always_comb begin
        row_sum = 4'(r_out_m5) + 4'(mfsp_pkg::RING_ROWS) + 4'(r_dy) - 4'(ry_eff);
        if (row_sum >= 4'(2 * mfsp_pkg::RING_ROWS)) begin
            row_sum = row_sum - 4'(2 * mfsp_pkg::RING_ROWS);
        end else if (row_sum >= 4'(mfsp_pkg::RING_ROWS)) begin
            row_sum = row_sum - 4'(mfsp_pkg::RING_ROWS);
        end
        col_sum = {1'b0, r_out_col} + (COL_W+1)'(r_dx) - (COL_W+1)'(rx_eff);
        if (r_first) begin
            rd_row = r_out_m5;
            rd_col = r_out_col;
        end else begin
            rd_row = row_sum[RSEL_W-1:0];
            rd_col = col_sum[COL_W-1:0];
        end
    end

    assign dx_end = (r_dx == {rx_eff, 1'b0});
    assign dy_end = (r_dy == {ry_eff, 1'b0});

    logic [PIX_W-1:0] rd_data;

    mfsp_ram #(
        .DATA_W(PIX_W),
        .DEPTH (mfsp_pkg::DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (in_acc && is_pix),
        .i_waddr({r_in_m5, r_in_col}),
        .i_wdata(i_pix.pixel_in),
        .i_raddr({rd_row, rd_col}),
        .o_rdata(rd_data)
    );

    // Sorter chain.
    mfsp_pkg::t_sort_ctl sort_ctl;
    logic [PIX_W-1:0]    sorted [mfsp_pkg::WIN_MAX];
    logic [PIX_W-1:0]    median;
    logic [PIX_W-1:0]    result;

    assign sort_ctl = '{clear: in_acc && emit && out_interior,
                        ins:   r_rd_v && !r_rd_ctr,
                        x:     rd_data};

    mfsp_sort u_sort (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (sort_ctl),
        .o_val  (sorted)
    );

    always_comb begin
        unique case ({rx_eff, ry_eff})
            4'b0101: median = sorted[4];
            4'b0110: median = sorted[7];
            4'b1001: median = sorted[7];
            default: median = sorted[12];
        endcase
        if (!r_interior) begin
            result = mfsp_pkg::PIX_BLACK;
        end else if (median == mfsp_pkg::PIX_BLACK || median == mfsp_pkg::PIX_WHITE) begin
            result = r_center;
        end else begin
            result = median;
        end
    end

    assign out_load = (r_state == ST_FIN) && (!r_ov || o_res.ready);

    // Sequencer and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_m5   <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_out_m5  <= '0;
            r_lag     <= '0;
            r_first   <= 1'b0;
            r_dx      <= '0;
            r_dy      <= '0;
            r_rd_v    <= 1'b0;
            r_rd_ctr  <= 1'b0;
            r_ov      <= 1'b0;
        end else if (cfg_hit) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_m5   <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_out_m5  <= '0;
            r_lag     <= '0;
        end else begin
            r_rd_v   <= (r_state == ST_READ);
            r_rd_ctr <= r_first;
            if (r_ov && o_res.ready && !out_load) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (is_pix) begin
                            if (in_col_end) begin
                                r_in_col <= '0;
                                if (r_in_row == h_eff - HREG_W'(1)) begin
                                    r_in_row <= '0;
                                    r_in_m5  <= '0;
                                end else begin
                                    r_in_row <= r_in_row + HREG_W'(1);
                                    r_in_m5  <= (r_in_m5 == RSEL_W'(mfsp_pkg::RING_ROWS - 1)) ?
                                                '0 : r_in_m5 + RSEL_W'(1);
                                end
                            end else begin
                                r_in_col <= r_in_col + COL_W'(1);
                            end
                        end
                        r_lag <= r_lag + LAG_W'(is_pix) - LAG_W'(emit);
                        if (emit) begin
                            r_interior <= out_interior;
                            r_first    <= 1'b1;
                            r_dx       <= '0;
                            r_dy       <= '0;
                            r_state    <= out_interior ? ST_READ : ST_FIN;
                        end
                    end
                end
                ST_READ: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                    end else if (dx_end) begin
                        r_dx <= '0;
                        if (dy_end) begin
                            r_state <= ST_WAIT;
                        end else begin
                            r_dy <= r_dy + 3'd1;
                        end
                    end else begin
                        r_dx <= r_dx + 3'd1;
                    end
                end
                ST_WAIT: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_load) begin
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                        if (out_col_end) begin
                            r_out_col <= '0;
                            if (r_out_row == h_eff - HREG_W'(1)) begin
                                r_out_row <= '0;
                                r_out_m5  <= '0;
                            end else begin
                                r_out_row <= r_out_row + HREG_W'(1);
                                r_out_m5  <= (r_out_m5 == RSEL_W'(mfsp_pkg::RING_ROWS - 1)) ?
                                             '0 : r_out_m5 + RSEL_W'(1);
                            end
                        end else begin
                            r_out_col <= r_out_col + COL_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The center pixel is the first word read for an interior result.
    always_ff @(posedge i_clk) begin
        if (r_rd_v && r_rd_ctr) begin
            r_center <= rd_data;
        end
        if (out_load) begin
            r_opix  <= result;
            r_olast <= (r_out_row == h_eff - HREG_W'(1)) && out_col_end;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.pixel_out = r_opix;
    assign o_res.last      = r_olast;

    `MFSP_ASSERT_ALWAYS(a_lag_bound, r_lag <= delay, "pending count exceeds the pipeline delay")
    `MFSP_ASSERT_ALWAYS(a_out_row_range, r_out_row < h_eff, "output row beyond frame height")
    `MFSP_ASSERT_IMPL(a_idle_no_read, r_state == ST_IDLE, !r_rd_v,
                      "line-store read still in flight while accepting")
    `MFSP_ASSERT_IMPL(a_fin_sorted, r_state == ST_FIN, !sort_ctl.ins && !sort_ctl.clear,
                      "sorter changes while the result is taken")
endmodule

// File: sv/mfsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfsp_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/mfsp_cell.sv
// One cell of the insertion sorter: holds one value, kept ascending along the chain.
// Depends on mfsp_pkg.
module mfsp_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfsp_pkg::t_sort_ctl i_ctl,
    input  mfsp_pkg::t_link     i_prev,
    output mfsp_pkg::t_link     o_link
);
    logic                       r_vld;
    logic [mfsp_pkg::PIX_W-1:0] r_val;
    logic                       gt;

    // An empty cell counts as larger than anything.
    assign gt = !r_vld || (r_val > i_ctl.x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.ins) begin
            priority if (i_prev.gt) begin
                r_vld <= i_prev.vld;
            end else if (gt) begin
                r_vld <= 1'b1;
            end else begin
                r_vld <= r_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            priority if (i_prev.gt) begin
                r_val <= i_prev.val;
            end else if (gt) begin
                r_val <= i_ctl.x;
            end else begin
                r_val <= r_val;
            end
        end
    end

    assign o_link = '{vld: r_vld, val: r_val, gt: gt};
endmodule

// File: sv/mfsp_sort.sv
// Chain of sorter cells; one value is inserted per cycle while ins is set, the chain stays ascending.
// Depends on mfsp_pkg and mfsp_cell.
module mfsp_sort (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mfsp_pkg::t_sort_ctl        i_ctl,
    output logic [mfsp_pkg::PIX_W-1:0] o_val [mfsp_pkg::WIN_MAX]
);
    mfsp_pkg::t_link links [mfsp_pkg::WIN_MAX+1];

    assign links[0] = '{vld: 1'b0, val: '0, gt: 1'b0};

    for (genvar g = 0; g < mfsp_pkg::WIN_MAX; g++) begin : g_cell
        mfsp_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (i_ctl),
            .i_prev (links[g]),
            .o_link (links[g+1])
        );
        assign o_val[g] = links[g+1].val;
    end
endmodule
